// ===== rtl/efr_pkg.sv =====
// Shared types, constants and CRC helpers for the escape frame receiver.
// No dependencies; imported by escape_frame_receiver_crc16.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;
    typedef logic [1:0]  code_t;
    typedef logic [1:0]  event_t;

    // Frame event codes
    localparam event_t EV_NONE     = 2'd0;
    localparam event_t EV_START    = 2'd1;
    localparam event_t EV_END_GOOD = 2'd2;
    localparam event_t EV_END_BAD  = 2'd3;

    // Escape byte values and their history codes
    localparam byte_t BYTE_ESC   = 8'h1B;
    localparam byte_t BYTE_START = 8'h01;
    localparam byte_t BYTE_END   = 8'h1A;
    localparam code_t CODE_OTHER = 2'd0;
    localparam code_t CODE_ESC   = 2'd1;
    localparam code_t CODE_START = 2'd2;
    localparam code_t CODE_END   = 2'd3;

    // History patterns: start escape is the full 16 bits, end escape the top 10
    localparam logic [15:0] START_PATTERN = 16'h55AA;
    localparam logic [9:0]  END_PATTERN   = 10'h157;

    // CRC seeds and reflected polynomial
    localparam crc_t X25_SEED    = 16'h6E23 ^ 16'hFFFF;
    localparam crc_t KERMIT_SEED = 16'hED50;
    localparam crc_t POLY_REFL   = 16'h8408;
    localparam crc_t CRC_XOR_OUT = 16'hFFFF;

    // Map a received byte to its 2-bit history code
    function automatic code_t byte_code(input byte_t b);
        code_t c;
        case (b)
            BYTE_ESC:   c = CODE_ESC;
            BYTE_START: c = CODE_START;
            BYTE_END:   c = CODE_END;
            default:    c = CODE_OTHER;
        endcase
        return c;
    endfunction

    // Feed one byte, LSB first, into a reflected CRC-16
    function automatic crc_t crc_feed(input crc_t crc, input byte_t b);
        crc_t c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ POLY_REFL;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/escape_frame_receiver_crc16.sv =====
// Escape frame receiver with dual CRC-16 check (X-25 and Kermit).
// Depends on efr_pkg for types, escape codes and the CRC byte update.
//
// Usage:
//   Input channel (in_valid / in_ready / byte_in) takes one received byte per
//   request. Output channel (out_valid / out_ready / byte_out, byte_recorded,
//   frame_event) returns exactly one result per byte, in order.
//   frame_event: none, start escape seen, frame end with good CRC, frame end
//   with bad CRC. byte_recorded marks bytes that belong to the frame body.
// Pipeline and throughput:
//   A byte is held in the input register, where the code history, the
//   two CRC updates and the frame check are evaluated; the result is
//   registered in the result register, which drives out_valid.
//   One byte per cycle while out_ready is high, set by the byte-wide CRC update.
// Reset:
//   rst_n clears history, recording flag and held count and reseeds both CRCs;
//   both pipeline stages come up empty.
// Stall:
//   While out_ready is low the result register holds; the input register
//   holds one more byte, and in_ready then drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module escape_frame_receiver_crc16
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire efr_pkg::byte_t byte_in,
    output logic                out_valid,
    input  wire                 out_ready,
    output efr_pkg::byte_t      byte_out,
    output logic                byte_recorded,
    output efr_pkg::event_t     frame_event
);
    import efr_pkg::*;

    // Input register
    logic        in_valid_reg;
    byte_t       in_byte_reg;

    // Frame state
    logic [15:0] history_reg;
    logic        recording_reg;
    crc_t        crc_x25_reg;
    crc_t        crc_kermit_reg;
    byte_t       held0_reg;
    byte_t       held1_reg;
    logic [1:0]  held_count_reg;

    // Result register
    logic        out_valid_reg;
    byte_t       out_byte_reg;
    logic        out_recorded_reg;
    event_t      out_event_reg;

    // Next-state values
    logic [15:0] history_next;
    logic        recording_next;
    crc_t        crc_x25_next;
    crc_t        crc_kermit_next;
    byte_t       held0_next;
    byte_t       held1_next;
    logic [1:0]  held_count_next;
    logic        recorded_next;
    event_t      event_next;

    logic        advance;
    logic        out_free;
    logic [15:0] received;
    crc_t        x25_final;
    logic        frame_good;

    // Handshake: advance the input stage when the result register frees up
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    // Evaluate one byte against the frame state
    always_comb
    begin
        crc_x25_next    = crc_x25_reg;
        crc_kermit_next = crc_kermit_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        held_count_next = held_count_reg;
        recording_next  = recording_reg;
        recorded_next   = 1'b0;
        event_next      = EV_NONE;

        // Record the byte, holding back the last two from the CRCs
        if (recording_reg)
        begin
            recorded_next = 1'b1;
            if (held_count_reg[1])
            begin
                crc_x25_next    = crc_feed(crc_x25_reg, held0_reg);
                crc_kermit_next = crc_feed(crc_kermit_reg, held0_reg);
                held0_next      = held1_reg;
                held1_next      = in_byte_reg;
            end
            else
            begin
                if (held_count_reg[0])
                begin
                    held1_next = in_byte_reg;
                end
                else
                begin
                    held0_next = in_byte_reg;
                end
                held_count_next = held_count_reg + 2'd1;
            end
        end

        history_next = {history_reg[13:0], byte_code(in_byte_reg)};

        // Check the frame tail against both CRC flavors
        received   = {held0_next, held1_next};
        x25_final  = crc_x25_next ^ CRC_XOR_OUT;
        frame_good = held_count_next[1]
                  && ((received == {x25_final[7:0], x25_final[15:8]})
                   || (received == crc_kermit_next));

        // Start escape restarts the frame; end escape closes it
        if (history_next == START_PATTERN)
        begin
            recording_next  = 1'b1;
            crc_x25_next    = X25_SEED;
            crc_kermit_next = KERMIT_SEED;
            held_count_next = 2'd0;
            recorded_next   = 1'b0;
            event_next      = EV_START;
        end
        else if (history_next[15:6] == END_PATTERN && recording_reg)
        begin
            recording_next = 1'b0;
            event_next     = frame_good ? EV_END_GOOD : EV_END_BAD;
        end
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input byte capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= byte_in;
        end
    end

    // Frame state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg    <= '0;
            recording_reg  <= 1'b0;
            crc_x25_reg    <= X25_SEED;
            crc_kermit_reg <= KERMIT_SEED;
            held_count_reg <= 2'd0;
        end
        else if (advance)
        begin
            history_reg    <= history_next;
            recording_reg  <= recording_next;
            crc_x25_reg    <= crc_x25_next;
            crc_kermit_reg <= crc_kermit_next;
            held_count_reg <= held_count_next;
        end
    end

    // Held body bytes
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg     <= in_byte_reg;
            out_recorded_reg <= recorded_next;
            out_event_reg    <= event_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_out      = out_byte_reg;
    assign byte_recorded = out_recorded_reg;
    assign frame_event   = out_event_reg;

endmodule

`default_nettype wire

// ===== tb/sv/escape_frame_receiver_crc16_test.sv =====
// Self-checking testbench for escape_frame_receiver_crc16: frames with X-25, Kermit and
// corrupted trailers, escape noise, random idling on both sides and a long output stall.
// Depends on efr_pkg and the escape_frame_receiver_crc16 RTL.
`timescale 1ns / 1ps

module escape_frame_receiver_crc16_test;

    import efr_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_BYTES   = 630;
    localparam int STALL_CYCLES   = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 8;

    typedef struct packed {
        byte_t  data;
        logic   recorded;
        event_t ev;
    } rx_result_t;

    typedef enum int {TRAILER_X25, TRAILER_KERMIT, TRAILER_CORRUPT} trailer_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    byte_t  byte_in = 8'h00;
    logic   out_valid;
    logic   out_ready = 1'b0;
    byte_t  byte_out;
    logic   byte_recorded;
    event_t frame_event;

    // Expected decoder state
    logic [15:0] hist_q = 16'h0000;
    logic        rec_on = 1'b0;
    crc_t        crc_x25 = X25_SEED;
    crc_t        crc_kermit = KERMIT_SEED;
    byte_t       held [2] = '{8'h00, 8'h00};
    logic [1:0]  held_n = 2'd0;

    rx_result_t  decoded_q [$];
    byte_t       outgoing [$];
    byte_t       frame_body [$];

    int   errors = 0;
    int   sent_count = 0;
    int   cycle_count = 0;
    bit   gaps_on = 1'b1;
    bit   stall_request = 1'b0;
    bit   stall_out = 1'b0;

    escape_frame_receiver_crc16 uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_out      (byte_out),
        .byte_recorded (byte_recorded),
        .frame_event   (frame_event)
    );

    always #5 clk = ~clk;

    // Reflected CRC-16, one bit at a time, LSB of the byte first
    function automatic crc_t crc16_refl_step(input crc_t crc, input byte_t b);
        crc_t c;
        logic fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ POLY_REFL;
            end
        end
        return c;
    endfunction

    function automatic code_t escape_code(input byte_t b);
        if (b == BYTE_ESC)
        begin
            return CODE_ESC;
        end
        if (b == BYTE_START)
        begin
            return CODE_START;
        end
        if (b == BYTE_END)
        begin
            return CODE_END;
        end
        return CODE_OTHER;
    endfunction

    // Advance the expected decoder by one accepted byte and queue its result
    function automatic void decode_byte(input byte_t b);
        rx_result_t  r;
        logic [15:0] rx;
        crc_t        x25;
        r.data     = b;
        r.recorded = 1'b0;
        r.ev       = EV_NONE;
        if (rec_on)
        begin
            if (held_n == 2'd2)
            begin
                crc_x25    = crc16_refl_step(crc_x25, held[0]);
                crc_kermit = crc16_refl_step(crc_kermit, held[0]);
                held[0]    = held[1];
                held[1]    = b;
            end
            else
            begin
                held[held_n[0]] = b;
                held_n          = held_n + 2'd1;
            end
            r.recorded = 1'b1;
        end
        hist_q = {hist_q[13:0], escape_code(b)};
        if (hist_q == START_PATTERN)
        begin
            rec_on     = 1'b1;
            crc_x25    = X25_SEED;
            crc_kermit = KERMIT_SEED;
            held_n     = 2'd0;
            r.recorded = 1'b0;
            r.ev       = EV_START;
        end
        else if (hist_q[15:6] == END_PATTERN && rec_on)
        begin
            rec_on = 1'b0;
            rx     = {held[0], held[1]};
            x25    = crc_x25 ^ CRC_XOR_OUT;
            x25    = {x25[7:0], x25[15:8]};
            if (held_n == 2'd2 && (rx == x25 || rx == crc_kermit))
            begin
                r.ev = EV_END_GOOD;
            end
            else
            begin
                r.ev = EV_END_BAD;
            end
        end
        decoded_q.push_back(r);
    endfunction

    // Offer one request, with an occasional gap first; hold until accepted
    task automatic send_byte(input byte_t b);
        if (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        decode_byte(b);
        sent_count++;
    endtask

    task automatic flush_outgoing();
        while (outgoing.size() != 0)
        begin
            send_byte(outgoing.pop_front());
        end
    endtask

    function automatic byte_t random_content();
        case ($urandom_range(0, 9))
            0:       return BYTE_ESC;
            1:       return BYTE_START;
            2:       return BYTE_END;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void append_start();
        repeat (4) outgoing.push_back(BYTE_ESC);
        repeat (4) outgoing.push_back(BYTE_START);
    endfunction

    function automatic void append_end_escape();
        repeat (4) outgoing.push_back(BYTE_ESC);
        outgoing.push_back(BYTE_END);
    endfunction

    // Start escape, frame_body, end escape with pad byte, then a two-byte trailer
    function automatic void append_frame(input trailer_t kind);
        crc_t  cx;
        crc_t  ck;
        crc_t  bad;
        byte_t covered [$];
        covered = frame_body;
        repeat (4) covered.push_back(BYTE_ESC);
        covered.push_back(BYTE_END);
        covered.push_back(byte_t'($urandom_range(0, 255)));
        cx = X25_SEED;
        ck = KERMIT_SEED;
        foreach (covered[i])
        begin
            cx = crc16_refl_step(cx, covered[i]);
            ck = crc16_refl_step(ck, covered[i]);
        end
        cx = cx ^ CRC_XOR_OUT;
        append_start();
        foreach (covered[i])
        begin
            outgoing.push_back(covered[i]);
        end
        case (kind)
            TRAILER_X25:
            begin
                outgoing.push_back(cx[7:0]);
                outgoing.push_back(cx[15:8]);
            end
            TRAILER_KERMIT:
            begin
                outgoing.push_back(ck[15:8]);
                outgoing.push_back(ck[7:0]);
            end
            default:
            begin
                bad = cx ^ crc_t'($urandom_range(1, 16'hFFFF));
                outgoing.push_back(bad[7:0]);
                outgoing.push_back(bad[15:8]);
            end
        endcase
    endfunction

    function automatic void random_frame(input int max_len);
        int len;
        frame_body.delete();
        len = $urandom_range(0, max_len);
        repeat (len) frame_body.push_back(random_content());
        append_frame(trailer_t'($urandom_range(0, 2)));
    endfunction

    // Compare each accepted result with the oldest expectation; drive out_ready
    always @(posedge clk)
    begin
        rx_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected result: byte %h recorded %b event %0d",
                         $time, byte_out, byte_recorded, frame_event);
                errors++;
            end
            else
            begin
                exp_r = decoded_q.pop_front();
                if (byte_out !== exp_r.data)
                begin
                    $display("%0t: byte_out expected %h actual %h",
                             $time, exp_r.data, byte_out);
                    errors++;
                end
                if (byte_recorded !== exp_r.recorded)
                begin
                    $display("%0t: byte_recorded expected %b actual %b (byte %h)",
                             $time, exp_r.recorded, byte_recorded, exp_r.data);
                    errors++;
                end
                if (frame_event !== exp_r.ev)
                begin
                    $display("%0t: frame_event expected %0d actual %0d (byte %h)",
                             $time, exp_r.ev, frame_event, exp_r.data);
                    errors++;
                end
            end
        end
        if (stall_out)
        begin
            out_ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Hold off the receiver for a fixed stretch on request
    always
    begin
        wait (stall_request);
        stall_request = 1'b0;
        stall_out     = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_out     = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, decoded_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Restart while recording, extreme body bytes, good X-25 trailer
    task automatic test_directed_frame();
        append_start();
        frame_body.delete();
        frame_body.push_back(8'hFF);
        frame_body.push_back(8'h00);
        append_frame(TRAILER_X25);
        flush_outgoing();
    endtask

    // End escape with nothing being recorded
    task automatic test_end_while_idle();
        append_end_escape();
        outgoing.push_back(8'h5A);
        outgoing.push_back(8'hA5);
        outgoing.push_back(8'h80);
        flush_outgoing();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_no_gaps();
        gaps_on = 1'b0;
        frame_body.delete();
        repeat (6) frame_body.push_back(byte_t'($urandom_range(0, 255)));
        append_frame(TRAILER_KERMIT);
        random_frame(20);
        random_frame(20);
        flush_outgoing();
        gaps_on = 1'b1;
    endtask

    // Long receiver stall while the sender keeps offering
    task automatic test_backpressure();
        stall_request = 1'b1;
        random_frame(30);
        random_frame(30);
        flush_outgoing();
    endtask

    // Mostly well-formed frames, plus broken frames, stray end escapes and noise
    task automatic test_random_traffic();
        int pick;
        int start_count;
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                random_frame(($urandom_range(0, 9) == 0) ? 40 : 12);
            end
            else if (pick < 75)
            begin
                append_start();
                repeat ($urandom_range(0, 6)) outgoing.push_back(random_content());
                repeat ($urandom_range(1, 4)) outgoing.push_back(BYTE_ESC);
                if ($urandom_range(0, 1))
                begin
                    outgoing.push_back(BYTE_END);
                end
            end
            else if (pick < 85)
            begin
                append_end_escape();
                repeat (3) outgoing.push_back(byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 10)) outgoing.push_back(random_content());
            end
            flush_outgoing();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frame();
        test_end_while_idle();
        test_no_gaps();
        test_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
